>>> rtl/mfmfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM flux encoder package
// Shared types, command and register codes, and helper functions for the
// MFM flux encoder with write precompensation.
// ----------------------------------------------------------------------------
package mfmfe_pkg;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_SYNC  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SHORT   = 2'd0;
    localparam logic [1:0] REG_MEDIUM  = 2'd1;
    localparam logic [1:0] REG_LONG    = 2'd2;
    localparam logic [1:0] REG_PRECOMP = 2'd3;

    // Reset values of the timing registers.
    localparam logic [7:0] SHORT_RESET  = 8'd48;
    localparam logic [7:0] MEDIUM_RESET = 8'd72;
    localparam logic [7:0] LONG_RESET   = 8'd96;

    // Index of the last pulse of the sync mark.
    localparam logic [3:0] SYNC_LAST_IDX = 4'd14;

    // Event queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CLS_SHORT  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LONG   = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DATA,
        FS_SYNC,
        FS_FLUSH
    } front_state_t;

    // One unit of work for the back end: a pulse of a class, or a flush.
    typedef struct packed {
        logic is_flush;
        cls_t cls;
        logic last;
    } event_t;

    // Timing configuration seen by the back end.
    typedef struct packed {
        logic [7:0] short_time;
        logic [7:0] medium_time;
        logic [7:0] long_time;
        logic [3:0] precomp;
    } cfg_t;

    // Interval class from the number of cells since the last transition.
    function automatic cls_t class_of(input logic [2:0] pend);
        cls_t c;
        if (pend <= 3'd1)
        begin
            c = CLS_SHORT;
        end
        else if (pend == 3'd2)
        begin
            c = CLS_MEDIUM;
        end
        else
        begin
            c = CLS_LONG;
        end
        return c;
    endfunction

    // Saturating add to the pending cell count.
    function automatic logic [2:0] pend_add(input logic [2:0] pend, input logic [1:0] inc);
        logic [3:0] sum;
        sum = {1'b0, pend} + {2'b00, inc};
        return sum[3] ? 3'd7 : sum[2:0];
    endfunction

    // Ticks for an interval class.
    function automatic logic [7:0] time_of(input cls_t c, input cfg_t cfg);
        logic [7:0] t;
        case (c)
            CLS_SHORT:  t = cfg.short_time;
            CLS_MEDIUM: t = cfg.medium_time;
            default:    t = cfg.long_time;
        endcase
        return t;
    endfunction

    // Class sequence of the sync mark: M L M L M S L M L M S L M L M.
    function automatic cls_t sync_class(input logic [3:0] idx);
        cls_t c;
        case (idx)
            4'd1, 4'd3, 4'd6, 4'd8, 4'd11, 4'd13: c = CLS_LONG;
            4'd5, 4'd10:                           c = CLS_SHORT;
            default:                               c = CLS_MEDIUM;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/mfmfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM encoder event queue
// Short register FIFO of pulse events between the front and back ends.
// ----------------------------------------------------------------------------
module mfmfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfmfe_pkg::event_t push_data,
    output logic              full,
    input  logic              pop,
    output mfmfe_pkg::event_t pop_data,
    output logic              empty
);

    mfmfe_pkg::event_t               entry_reg [mfmfe_pkg::QUEUE_DEPTH];
    logic [mfmfe_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [mfmfe_pkg::QUEUE_AW-1:0]  wr_ptr_next;
    logic [mfmfe_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [mfmfe_pkg::QUEUE_AW-1:0]  rd_ptr_next;
    logic [mfmfe_pkg::QUEUE_AW:0]    count_reg;
    logic [mfmfe_pkg::QUEUE_AW:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    // Status and read data.
    assign full     = (count_reg == (mfmfe_pkg::QUEUE_AW+1)'(mfmfe_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mfmfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM encoder front end
// Accepts commands; while the queue has room, walks data bytes one bit per
// cycle and the sync mark one pulse per cycle, and queues pulse/flush events.
// ----------------------------------------------------------------------------
module mfmfe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [7:0]        data_byte,
    output logic              push,
    output mfmfe_pkg::event_t push_data,
    input  logic              queue_full
);

    mfmfe_pkg::front_state_t state_reg;
    mfmfe_pkg::front_state_t state_next;
    logic [7:0]              byte_reg;
    logic [7:0]              byte_next;
    logic [3:0]              cnt_reg;
    logic [3:0]              cnt_next;
    logic                    prior_bit_reg;
    logic                    prior_bit_next;
    logic [2:0]              pend_reg;
    logic [2:0]              pend_next;

    logic                    step_go;
    logic                    step_final;
    logic                    in_take;
    logic [2:0]              bit_pos;
    logic                    bit_d;
    logic                    later_event;

    assign bit_pos = ~cnt_reg[2:0];
    assign bit_d   = byte_reg[bit_pos];

    // A step runs whenever work is pending and the queue has room.
    assign step_go = (state_reg != mfmfe_pkg::FS_IDLE) && !queue_full;

    always_comb
    begin
        case (state_reg)
            mfmfe_pkg::FS_DATA:  step_final = (cnt_reg[2:0] == 3'd7);
            mfmfe_pkg::FS_SYNC:  step_final = (cnt_reg == mfmfe_pkg::SYNC_LAST_IDX);
            mfmfe_pkg::FS_FLUSH: step_final = 1'b1;
            default:             step_final = 1'b0;
        endcase
    end

    // A new command is taken while idle or in the cycle the last step runs.
    assign in_ready = (state_reg == mfmfe_pkg::FS_IDLE) || (step_go && step_final);
    assign in_take  = in_valid && in_ready;

    // Later bits of the byte give a pulse unless only bit 0 remains and it is
    // a zero that follows a one.
    assign later_event = (bit_pos >= 3'd2) ||
                         ((bit_pos == 3'd1) && !(byte_reg[0] == 1'b0 && bit_d == 1'b1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (in_take)
        begin
            case (cmd)
                mfmfe_pkg::CMD_DATA:  state_next = mfmfe_pkg::FS_DATA;
                mfmfe_pkg::CMD_SYNC:  state_next = mfmfe_pkg::FS_SYNC;
                mfmfe_pkg::CMD_FLUSH: state_next = mfmfe_pkg::FS_FLUSH;
                default:              state_next = mfmfe_pkg::FS_IDLE;
            endcase
        end
        else if (step_go && step_final)
        begin
            state_next = mfmfe_pkg::FS_IDLE;
        end
    end

    // Event generation and bit-walk state.
    always_comb
    begin
        push               = 1'b0;
        push_data.is_flush = 1'b0;
        push_data.cls      = mfmfe_pkg::CLS_SHORT;
        push_data.last     = 1'b0;
        prior_bit_next     = prior_bit_reg;
        pend_next          = pend_reg;
        byte_next          = byte_reg;
        cnt_next           = cnt_reg;

        if (step_go)
        begin
            cnt_next = cnt_reg + 4'd1;
            case (state_reg)
                mfmfe_pkg::FS_DATA:
                begin
                    prior_bit_next = bit_d;
                    if (bit_d)
                    begin
                        // Clock cell counted, then a data transition.
                        push           = 1'b1;
                        push_data.cls  = mfmfe_pkg::class_of(mfmfe_pkg::pend_add(pend_reg, 2'd1));
                        push_data.last = !later_event;
                        pend_next      = 3'd0;
                    end
                    else if (!prior_bit_reg)
                    begin
                        // Clock transition, then an empty data cell.
                        push           = 1'b1;
                        push_data.cls  = mfmfe_pkg::class_of(pend_reg);
                        push_data.last = !later_event;
                        pend_next      = 3'd1;
                    end
                    else
                    begin
                        // No transition in either cell.
                        pend_next = mfmfe_pkg::pend_add(pend_reg, 2'd2);
                    end
                end
                mfmfe_pkg::FS_SYNC:
                begin
                    push           = 1'b1;
                    push_data.cls  = mfmfe_pkg::sync_class(cnt_reg);
                    push_data.last = step_final;
                    if (step_final)
                    begin
                        prior_bit_next = 1'b1;
                        pend_next      = 3'd0;
                    end
                end
                mfmfe_pkg::FS_FLUSH:
                begin
                    push               = 1'b1;
                    push_data.is_flush = 1'b1;
                    push_data.last     = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end

        if (in_take)
        begin
            byte_next = data_byte;
            cnt_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfmfe_pkg::FS_IDLE;
            cnt_reg       <= 4'd0;
            prior_bit_reg <= 1'b0;
            pend_reg      <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prior_bit_reg <= prior_bit_next;
            pend_reg      <= pend_next;
        end
    end

    // Byte holding register needs no reset.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

>>> rtl/mfmfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM encoder back end
// Takes one queued event per cycle unless the output stalls, precompensates
// via the held pulse, turns classes into ticks and loads the output register.
// ----------------------------------------------------------------------------
module mfmfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mfmfe_pkg::cfg_t   cfg,
    input  logic              queue_empty,
    input  mfmfe_pkg::event_t ev,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        pulse_time,
    output logic              last_pulse
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             pulse_time_reg;
    logic [7:0]             pulse_time_next;
    logic                   last_pulse_reg;
    logic                   last_pulse_next;
    mfmfe_pkg::cls_t        held_class_reg;
    mfmfe_pkg::cls_t        held_class_next;
    logic                   held_valid_reg;
    logic                   held_valid_next;
    logic [5:0]             edge_offset_reg;
    logic [5:0]             edge_offset_next;

    logic                   produce;
    logic [7:0]             result;
    logic [5:0]             shift;
    logic [7:0]             held_time;
    logic [7:0]             edge_ext;

    // An event is taken when the output register is free or being drained.
    assign pop = !queue_empty && (!out_valid_reg || out_ready);

    assign held_time = mfmfe_pkg::time_of(held_class_reg, cfg);
    assign edge_ext  = {{2{edge_offset_reg[5]}}, edge_offset_reg};

    // Shift at a boundary between a short and a longer interval.
    always_comb
    begin
        if (held_class_reg == mfmfe_pkg::CLS_SHORT && ev.cls != mfmfe_pkg::CLS_SHORT)
        begin
            shift = 6'd0 - {2'b00, cfg.precomp};
        end
        else if (held_class_reg != mfmfe_pkg::CLS_SHORT && ev.cls == mfmfe_pkg::CLS_SHORT)
        begin
            shift = {2'b00, cfg.precomp};
        end
        else
        begin
            shift = 6'd0;
        end
    end

    // Pulse path and precompensation state.
    always_comb
    begin
        produce          = 1'b0;
        result           = 8'd0;
        held_class_next  = held_class_reg;
        held_valid_next  = held_valid_reg;
        edge_offset_next = edge_offset_reg;

        if (ev.is_flush)
        begin
            produce          = held_valid_reg;
            result           = held_time - edge_ext;
            held_valid_next  = 1'b0;
            edge_offset_next = 6'd0;
        end
        else if (cfg.precomp == 4'd0)
        begin
            produce = 1'b1;
            result  = mfmfe_pkg::time_of(ev.cls, cfg);
        end
        else if (!held_valid_reg)
        begin
            held_class_next = ev.cls;
            held_valid_next = 1'b1;
        end
        else
        begin
            produce          = 1'b1;
            result           = held_time + {{2{shift[5]}}, shift} - edge_ext;
            edge_offset_next = shift;
            held_class_next  = ev.cls;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        pulse_time_next = pulse_time_reg;
        last_pulse_next = last_pulse_reg;
        if (pop && produce)
        begin
            out_valid_next  = 1'b1;
            pulse_time_next = result;
            last_pulse_next = ev.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            held_class_reg  <= mfmfe_pkg::CLS_SHORT;
            held_valid_reg  <= 1'b0;
            edge_offset_reg <= 6'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                held_class_reg  <= held_class_next;
                held_valid_reg  <= held_valid_next;
                edge_offset_reg <= edge_offset_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        pulse_time_reg <= pulse_time_next;
        last_pulse_reg <= last_pulse_next;
    end

    assign out_valid  = out_valid_reg;
    assign pulse_time = pulse_time_reg;
    assign last_pulse = last_pulse_reg;

endmodule

>>> rtl/mfm_flux_encoder_precomp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM flux encoder with write precompensation
// Turns commands (data byte, sync mark, flush) into MFM flux interval times.
//
//   Channel   Signals                          Direction  Transfer when
//   input     in_valid/in_ready, cmd, byte     in         in_valid & in_ready
//   output    out_valid/out_ready, time, last  out        out_valid & out_ready
//   config    cfg_valid/cfg_ready, index, data in         cfg_valid & cfg_ready
//
// The front end walks a data byte one bit per cycle and a sync mark one pulse
// per cycle; a flush queues one flush event and an unused command nothing.
// The back end handles one event per cycle, so one pulse per cycle is the
// output limit. A four-entry event queue decouples the two ends; the front
// stalls only when it is full, the back only while the output is held.
// Reset clears all encoder state and loads the default timing registers.
// ----------------------------------------------------------------------------
module mfm_flux_encoder_precomp (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pulse_time,
    output logic       last_pulse,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    mfmfe_pkg::cfg_t   cfg_reg;
    mfmfe_pkg::cfg_t   cfg_next;
    logic              q_push;
    mfmfe_pkg::event_t q_push_data;
    logic              q_full;
    logic              q_pop;
    mfmfe_pkg::event_t q_pop_data;
    logic              q_empty;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                mfmfe_pkg::REG_SHORT:   cfg_next.short_time  = cfg_data;
                mfmfe_pkg::REG_MEDIUM:  cfg_next.medium_time = cfg_data;
                mfmfe_pkg::REG_LONG:    cfg_next.long_time   = cfg_data;
                mfmfe_pkg::REG_PRECOMP: cfg_next.precomp     = cfg_data[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_time  <= mfmfe_pkg::SHORT_RESET;
            cfg_reg.medium_time <= mfmfe_pkg::MEDIUM_RESET;
            cfg_reg.long_time   <= mfmfe_pkg::LONG_RESET;
            cfg_reg.precomp     <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Command decode and bit walk.
    mfmfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .push       (q_push),
        .push_data  (q_push_data),
        .queue_full (q_full)
    );

    // Event queue.
    mfmfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Precompensation and timing.
    mfmfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (q_empty),
        .ev          (q_pop_data),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_time  (pulse_time),
        .last_pulse  (last_pulse)
    );

endmodule

>>> tb/sv/mfm_flux_encoder_precomp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM flux encoder with write precompensation: self-checking testbench
// Drives data bytes, sync marks and flushes into the encoder under random
// gaps and output stalls. An in-bench predictor tracks the encoder state and
// timing registers and works out the flux intervals each command should
// give. Every output transfer is checked against the oldest expected pulse.
// ----------------------------------------------------------------------------
module mfm_flux_encoder_precomp_tb;

    // Cycles allowed after the last expected pulse for work with no output.
    localparam int DRAIN_CYCLES = 40;
    // Bound on any wait for outstanding pulses.
    localparam int DRAIN_LIMIT  = 5000;
    // Hard stop for the whole run.
    localparam int LIMIT_NS     = 5_000_000;
    // Command code with no function; the block ignores it.
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    // Interval classes of the sync mark, in write order.
    localparam mfmfe_pkg::cls_t MARK_SEQ [0:14] = '{
        mfmfe_pkg::CLS_MEDIUM, mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM,
        mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM,
        mfmfe_pkg::CLS_SHORT, mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM,
        mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM,
        mfmfe_pkg::CLS_SHORT, mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM,
        mfmfe_pkg::CLS_LONG, mfmfe_pkg::CLS_MEDIUM
    };

    // Block ports.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] cmd       = mfmfe_pkg::CMD_DATA;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] pulse_time;
    logic       last_pulse;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = mfmfe_pkg::REG_SHORT;
    logic [7:0] cfg_data  = 8'd0;

    // Predicted timing registers.
    logic [7:0] short_ticks  = mfmfe_pkg::SHORT_RESET;
    logic [7:0] medium_ticks = mfmfe_pkg::MEDIUM_RESET;
    logic [7:0] long_ticks   = mfmfe_pkg::LONG_RESET;
    logic [3:0] precomp      = 4'd0;

    // Predicted encoder state.
    logic            prior_bit  = 1'b0;
    logic [2:0]      pend_cells = 3'd0;
    mfmfe_pkg::cls_t held_cls   = mfmfe_pkg::CLS_SHORT;
    logic            held_vld   = 1'b0;
    logic [5:0]      edge_ofs   = 6'd0;

    // Pulses still to come out, oldest first.
    logic [7:0] pulse_times_due [$];
    logic       last_flags_due  [$];

    int mismatch_count = 0;

    // Traffic shaping shared by the sender and the receiver.
    bit idling_on     = 1'b1;
    int hold_request  = 0;
    int hold_left     = 0;
    int stall_left    = 0;

    mfm_flux_encoder_precomp DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pulse_time (pulse_time),
        .last_pulse (last_pulse),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] interval_ticks(input mfmfe_pkg::cls_t c);
        logic [7:0] t;
        case (c)
            mfmfe_pkg::CLS_SHORT:  t = short_ticks;
            mfmfe_pkg::CLS_MEDIUM: t = medium_ticks;
            default:               t = long_ticks;
        endcase
        return t;
    endfunction

    // A pulse either goes out directly, gets held, or releases the held one
    // shifted at a short/long boundary.
    function automatic void place_pulse(input mfmfe_pkg::cls_t c);
        logic [5:0] shift;
        logic [7:0] t;
        if (precomp == 4'd0)
        begin
            pulse_times_due.push_back(interval_ticks(c));
            last_flags_due.push_back(1'b0);
        end
        else if (!held_vld)
        begin
            held_cls = c;
            held_vld = 1'b1;
        end
        else
        begin
            shift = 6'd0;
            if (held_cls == mfmfe_pkg::CLS_SHORT && c != mfmfe_pkg::CLS_SHORT)
            begin
                shift = 6'd0 - {2'b00, precomp};
            end
            else if (held_cls != mfmfe_pkg::CLS_SHORT && c == mfmfe_pkg::CLS_SHORT)
            begin
                shift = {2'b00, precomp};
            end
            t = interval_ticks(held_cls) + {{2{shift[5]}}, shift}
                - {{2{edge_ofs[5]}}, edge_ofs};
            pulse_times_due.push_back(t);
            last_flags_due.push_back(1'b0);
            edge_ofs = shift;
            held_cls = c;
        end
    endfunction

    // A transition closes the interval of the cells counted so far.
    function automatic void close_interval();
        mfmfe_pkg::cls_t c;
        if (pend_cells <= 3'd1)
        begin
            c = mfmfe_pkg::CLS_SHORT;
        end
        else if (pend_cells == 3'd2)
        begin
            c = mfmfe_pkg::CLS_MEDIUM;
        end
        else
        begin
            c = mfmfe_pkg::CLS_LONG;
        end
        pend_cells = 3'd0;
        place_pulse(c);
    endfunction

    function automatic void count_cell();
        if (pend_cells != 3'd7)
        begin
            pend_cells = pend_cells + 3'd1;
        end
    endfunction

    // Works out the pulses of one command and queues them.
    function automatic void compute_pulses(input logic [1:0] c, input logic [7:0] b);
        int   first;
        logic d;
        first = pulse_times_due.size();
        case (c)
            mfmfe_pkg::CMD_DATA:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    d = b[i];
                    if (!prior_bit && !d)
                    begin
                        close_interval();
                    end
                    else
                    begin
                        count_cell();
                    end
                    if (d)
                    begin
                        close_interval();
                    end
                    else
                    begin
                        count_cell();
                    end
                    prior_bit = d;
                end
            end
            mfmfe_pkg::CMD_SYNC:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    place_pulse(MARK_SEQ[i]);
                end
                prior_bit  = 1'b1;
                pend_cells = 3'd0;
            end
            mfmfe_pkg::CMD_FLUSH:
            begin
                if (held_vld)
                begin
                    pulse_times_due.push_back(interval_ticks(held_cls)
                                              - {{2{edge_ofs[5]}}, edge_ofs});
                    last_flags_due.push_back(1'b0);
                end
                held_vld = 1'b0;
                edge_ofs = 6'd0;
            end
            default:
            begin
            end
        endcase
        if (pulse_times_due.size() > first)
        begin
            last_flags_due[last_flags_due.size() - 1] = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stalls and checking
    // ------------------------------------------------------------------

    // Receiver: long holds on request, otherwise random stall bursts.
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 8) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Each output transfer is compared with the oldest expected pulse.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pulse_times_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: pulse expected none actual pulse_time %0d last_pulse %0b",
                         $time, pulse_time, last_pulse);
            end
            else
            begin
                if (pulse_time !== pulse_times_due[0])
                begin
                    mismatch_count++;
                    $display("%0t: pulse_time expected %0d actual %0d",
                             $time, pulse_times_due[0], pulse_time);
                end
                if (last_pulse !== last_flags_due[0])
                begin
                    mismatch_count++;
                    $display("%0t: last_pulse expected %0b actual %0b",
                             $time, last_flags_due[0], last_pulse);
                end
                void'(pulse_times_due.pop_front());
                void'(last_flags_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // Offers one command and returns at the edge of its transfer.
    task automatic send_item(input logic [1:0] c, input logic [7:0] b);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        data_byte <= b;
        compute_pulses(c, b);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops offering and waits until every expected pulse has come out,
    // then lets the block settle.
    task automatic wait_drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pulse_times_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mfmfe_pkg::REG_SHORT:  short_ticks  = val;
            mfmfe_pkg::REG_MEDIUM: medium_ticks = val;
            mfmfe_pkg::REG_LONG:   long_ticks   = val;
            default:               precomp      = val[3:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default timings, no precompensation: byte extremes, sync, idle flush
    // and the unused command.
    task automatic test_reset_defaults();
        send_item(mfmfe_pkg::CMD_DATA, 8'h00);
        send_item(mfmfe_pkg::CMD_DATA, 8'hFF);
        send_item(mfmfe_pkg::CMD_DATA, 8'hA5);
        send_item(mfmfe_pkg::CMD_SYNC, 8'h00);
        send_item(mfmfe_pkg::CMD_DATA, 8'h5A);
        send_item(mfmfe_pkg::CMD_FLUSH, 8'hFF);
        send_item(CMD_RESERVED, 8'h3C);
        wait_drain();
    endtask

    // Register extremes with full precompensation, so that shifts wrap
    // around zero and 255; flush with and without a held pulse.
    task automatic test_register_extremes();
        write_reg(mfmfe_pkg::REG_SHORT, 8'd0);
        write_reg(mfmfe_pkg::REG_MEDIUM, 8'd255);
        write_reg(mfmfe_pkg::REG_LONG, 8'd128);
        write_reg(mfmfe_pkg::REG_PRECOMP, 8'hFF);
        send_item(mfmfe_pkg::CMD_DATA, 8'h00);
        send_item(mfmfe_pkg::CMD_DATA, 8'h01);
        send_item(mfmfe_pkg::CMD_DATA, 8'h80);
        send_item(mfmfe_pkg::CMD_SYNC, 8'h00);
        send_item(mfmfe_pkg::CMD_DATA, 8'hFF);
        send_item(mfmfe_pkg::CMD_FLUSH, 8'h00);
        send_item(mfmfe_pkg::CMD_FLUSH, 8'h00);
        wait_drain();
    endtask

    // Precompensation switched off while a pulse is held: new pulses go out
    // directly and the held one waits for the flush.
    task automatic test_precomp_off_while_held();
        write_reg(mfmfe_pkg::REG_PRECOMP, 8'h01);
        send_item(mfmfe_pkg::CMD_DATA, 8'h92);
        wait_drain();
        write_reg(mfmfe_pkg::REG_PRECOMP, 8'hF0);
        send_item(mfmfe_pkg::CMD_DATA, 8'h6D);
        send_item(mfmfe_pkg::CMD_FLUSH, 8'h00);
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while sync marks and bytes
    // keep coming, so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        write_reg(mfmfe_pkg::REG_SHORT, 8'd40);
        write_reg(mfmfe_pkg::REG_MEDIUM, 8'd60);
        write_reg(mfmfe_pkg::REG_LONG, 8'd80);
        write_reg(mfmfe_pkg::REG_PRECOMP, 8'h03);
        idling_on = 1'b0;
        @(posedge clk);
        hold_request = 120;
        for (int i = 0; i < 10; i++)
        begin
            if (i % 3 == 0)
                send_item(mfmfe_pkg::CMD_SYNC, 8'h00);
            else
                send_item(mfmfe_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(mfmfe_pkg::CMD_FLUSH, 8'h00);
        wait_drain();
        idling_on = 1'b1;
    endtask

    // Random command mix over several register settings; the last phase
    // runs without any idling.
    task automatic test_random_traffic();
        int         sent;
        int         r;
        logic [7:0] b;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(mfmfe_pkg::REG_SHORT, 8'd255);
                    write_reg(mfmfe_pkg::REG_MEDIUM, 8'd255);
                    write_reg(mfmfe_pkg::REG_LONG, 8'd255);
                    write_reg(mfmfe_pkg::REG_PRECOMP, 8'h0F);
                end
                1:
                begin
                    write_reg(mfmfe_pkg::REG_SHORT, 8'd0);
                    write_reg(mfmfe_pkg::REG_MEDIUM, 8'd0);
                    write_reg(mfmfe_pkg::REG_LONG, 8'd0);
                    write_reg(mfmfe_pkg::REG_PRECOMP, 8'hA1);
                end
                2:
                begin
                    write_reg(mfmfe_pkg::REG_SHORT, 8'd48);
                    write_reg(mfmfe_pkg::REG_MEDIUM, 8'd72);
                    write_reg(mfmfe_pkg::REG_LONG, 8'd96);
                    write_reg(mfmfe_pkg::REG_PRECOMP, 8'h50);
                end
                default:
                begin
                    write_reg(mfmfe_pkg::REG_SHORT, 8'($urandom_range(0, 255)));
                    write_reg(mfmfe_pkg::REG_MEDIUM, 8'($urandom_range(0, 255)));
                    write_reg(mfmfe_pkg::REG_LONG, 8'($urandom_range(0, 255)));
                    write_reg(mfmfe_pkg::REG_PRECOMP, 8'($urandom_range(0, 255)));
                end
            endcase
            idling_on = (phase != 5) && (phase != 3);
            if (phase == 4)
            begin
                @(posedge clk);
                hold_request = 90;
            end
            sent = 0;
            while (sent < 64)
            begin
                r = $urandom_range(0, 99);
                b = 8'($urandom_range(0, 255));
                if (r < 8)
                    b = (r < 4) ? 8'h00 : 8'hFF;
                if (r < 55)
                begin
                    send_item(mfmfe_pkg::CMD_DATA, b);
                    sent++;
                end
                else if (r < 75)
                begin
                    send_item(mfmfe_pkg::CMD_SYNC, b);
                    sent++;
                end
                else if (r < 96)
                begin
                    send_item(mfmfe_pkg::CMD_FLUSH, b);
                    sent++;
                end
                else
                begin
                    // Unused command: ignored by the block.
                    send_item(CMD_RESERVED, b);
                end
                // The sender pauses once per phase until all pulses are out.
                if (sent == 32 && r < 96)
                    wait_drain();
            end
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_precomp_off_while_held();
        test_output_backpressure();
        test_random_traffic();
        wait_drain();
        if (pulse_times_due.size() != 0)
        begin
            $display("%0t: %0d expected pulses never came out, next expected %0d",
                     $time, pulse_times_due.size(), pulse_times_due[0]);
            mismatch_count += pulse_times_due.size();
        end
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
